// ----- hw/rtl/mwma_pkg.sv -----
// ----------------------------------------------------------------------------
// mwma_pkg
// Shared constants, types and helpers for the multi-window moving average.
// ----------------------------------------------------------------------------
package mwma_pkg;

  localparam int RING_DEPTH   = 256;
  localparam int MAX_WINDOWS  = 4;
  localparam int SAMPLE_BITS  = 16;

  localparam int LENGTH_REGS  = 4;
  localparam int NUM_SLOTS    = (MAX_WINDOWS < LENGTH_REGS) ? MAX_WINDOWS : LENGTH_REGS;
  localparam int ADDR_W       = $clog2(RING_DEPTH);
  localparam int FILL_W       = $clog2(RING_DEPTH + 1);
  localparam int LEN_W        = 9;
  localparam int SLOT_W       = 2;
  localparam int CNT_W        = 3;
  localparam int SUM_W        = 24;
  localparam int AVG_W        = 24;
  localparam int FRAC_BITS    = 8;
  localparam int NUM_W        = SUM_W + FRAC_BITS;
  localparam int DIV_STEPS    = 4;
  localparam int DIV_ITERS    = NUM_W / DIV_STEPS;
  localparam int STEP_W       = $clog2(DIV_ITERS);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 9;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WINDOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_WINDOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOURTH_WINDOW  = 3'd4;

  typedef struct packed {
    logic                              clear;
    logic [CNT_W-1:0]                  active;
    logic [NUM_SLOTS-1:0][LEN_W-1:0]   len;
  } ctrl_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic [LEN_W-1:0]        len;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } job_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W-1:0] top);
    logic [LEN_W-1:0] r;
    r = (v == '0) ? LEN_W'(1) : v;
    if (r > top) r = top;
    return r;
  endfunction

endpackage

// ----- hw/rtl/mwma_ram.sv -----
// ----------------------------------------------------------------------------
// mwma_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mwma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/mwma_fifo.sv -----
// ----------------------------------------------------------------------------
// mwma_fifo
// Short job queue between the sum update front end and the divider.
// ----------------------------------------------------------------------------
module mwma_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mwma_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output mwma_pkg::job_t head,
  output logic           empty
);

  mwma_pkg::job_t                    entry_r [mwma_pkg::QUEUE_DEPTH];
  logic [mwma_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [mwma_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [mwma_pkg::QCNT_W-1:0]       count_r;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (count_r == mwma_pkg::QCNT_W'(mwma_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (count_r <= mwma_pkg::QCNT_W'(mwma_pkg::QUEUE_DEPTH))
        else $error("job queue overfilled");
    end
  end

endmodule

// ----- hw/rtl/mwma_front.sv -----
// ----------------------------------------------------------------------------
// mwma_front
// Takes samples, updates the ring and the window sums, queues average jobs.
// ----------------------------------------------------------------------------
module mwma_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mwma_pkg::ctrl_t                      ctrl,
  input  logic                                 in_push,
  input  logic signed [mwma_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                 in_full,
  output logic                                 q_push,
  output mwma_pkg::job_t                       q_job,
  input  logic                                 q_full
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam int SB = mwma_pkg::SAMPLE_BITS;

  logic [2:0]                       state_r;
  logic [mwma_pkg::SLOT_W-1:0]      slot_r;
  logic [SB-1:0]                    sample_r;
  logic [mwma_pkg::ADDR_W-1:0]      np_r;
  logic [mwma_pkg::ADDR_W-1:0]      newest_r;
  logic [mwma_pkg::FILL_W-1:0]      fill_r;
  logic signed [mwma_pkg::SUM_W-1:0] sums_r [mwma_pkg::NUM_SLOTS];

  logic [mwma_pkg::LEN_W-1:0]       cur_len;
  logic [mwma_pkg::ADDR_W-1:0]      rd_addr;
  logic [SB-1:0]                    rd_data;
  logic [SB-1:0]                    old;
  logic signed [SB:0]               diff;
  logic signed [mwma_pkg::SUM_W-1:0] diff_ext;
  logic [mwma_pkg::FILL_W-1:0]      fill_nxt;
  logic                             wr_en;

  assign cur_len  = ctrl.len[slot_r];
  assign rd_addr  = np_r - cur_len[mwma_pkg::ADDR_W-1:0];
  assign old      = (fill_r >= mwma_pkg::FILL_W'(cur_len)) ? rd_data : '0;
  assign diff     = $signed({sample_r[SB-1], sample_r}) - $signed({old[SB-1], old});
  assign diff_ext = {{(mwma_pkg::SUM_W-SB-1){diff[SB]}}, diff};
  assign fill_nxt = (fill_r == mwma_pkg::FILL_W'(mwma_pkg::RING_DEPTH)) ? fill_r
                                                                         : fill_r + 1'b1;
  assign wr_en    = (state_r == S_WRITE);
  assign in_full  = (state_r != S_IDLE);
  assign q_push   = (state_r == S_EMIT) && !q_full;

  assign q_job.slot = slot_r;
  assign q_job.len  = cur_len;
  assign q_job.sum  = sums_r[slot_r];
  assign q_job.last = (slot_r == '0);

  mwma_ram #(
    .WIDTH (SB),
    .DEPTH (mwma_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (np_r),
    .wr_data (sample_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      state_r  <= S_IDLE;
      slot_r   <= '0;
      newest_r <= '0;
      fill_r   <= '0;
      for (int i = 0; i < mwma_pkg::NUM_SLOTS; i++) sums_r[i] <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_push) begin
            sample_r <= in_sample;
            np_r     <= newest_r + 1'b1;
            slot_r   <= '0;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          sums_r[slot_r] <= sums_r[slot_r] + diff_ext;
          if (slot_r == mwma_pkg::SLOT_W'(mwma_pkg::NUM_SLOTS - 1)) begin
            state_r <= S_WRITE;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_WRITE: begin
          newest_r <= np_r;
          fill_r   <= fill_nxt;
          if (fill_nxt >= mwma_pkg::FILL_W'(ctrl.len[0])) begin
            slot_r  <= mwma_pkg::SLOT_W'(ctrl.active - 1'b1);
            state_r <= S_EMIT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!q_full) begin
            if (slot_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              slot_r <= slot_r - 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  property p_fill_bound;
    @(posedge clk) disable iff (!rst_n)
      fill_r <= mwma_pkg::FILL_W'(mwma_pkg::RING_DEPTH);
  endproperty
  a_fill_bound: assert property (p_fill_bound) else $error("fill count overran ring");

  property p_emit_slot;
    @(posedge clk) disable iff (!rst_n)
      q_push |-> (mwma_pkg::CNT_W'(slot_r) < ctrl.active);
  endproperty
  a_emit_slot: assert property (p_emit_slot) else $error("job for inactive window");

  property p_last_ends;
    @(posedge clk) disable iff (!rst_n || ctrl.clear)
      (q_push && q_job.last) |=> (state_r == S_IDLE);
  endproperty
  a_last_ends: assert property (p_last_ends) else $error("emit continued past last");

endmodule

// ----- hw/rtl/mwma_back.sv -----
// ----------------------------------------------------------------------------
// mwma_back
// Floor divides each queued window sum by its length, holds the result.
// ----------------------------------------------------------------------------
module mwma_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mwma_pkg::job_t                       q_head,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic [mwma_pkg::SLOT_W-1:0]          out_window_slot,
  output logic [mwma_pkg::LEN_W-1:0]           out_window_length,
  output logic signed [mwma_pkg::AVG_W-1:0]    out_average,
  output logic                                 out_last
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  localparam int LW = mwma_pkg::LEN_W;
  localparam int NW = mwma_pkg::NUM_W;

  logic [1:0]                   state_r;
  logic [mwma_pkg::STEP_W-1:0]  step_r;
  logic [NW-1:0]                num_r;
  logic [LW-1:0]                rem_r;
  logic                         neg_r;
  logic [mwma_pkg::SLOT_W-1:0]  slot_r;
  logic [LW-1:0]                len_r;
  logic                         last_r;
  logic                         out_valid_r;
  logic [mwma_pkg::SLOT_W-1:0]  o_slot_r;
  logic [LW-1:0]                o_len_r;
  logic [mwma_pkg::AVG_W-1:0]   o_avg_r;
  logic                         o_last_r;

  logic [mwma_pkg::SUM_W-1:0]   mag;
  logic [NW-1:0]                num_nxt;
  logic [LW-1:0]                rem_nxt;
  logic [NW-1:0]                quot;
  logic                         load_out;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign load_out = (state_r == B_DONE) && (!out_valid_r || out_pop);
  assign mag      = q_head.sum[mwma_pkg::SUM_W-1] ? -q_head.sum : q_head.sum;
  assign quot     = neg_r ? -(num_r + NW'(rem_r != '0)) : num_r;

  always_comb begin
    logic [LW:0]   t;
    logic [NW-1:0] n;
    logic [LW-1:0] r;
    n = num_r;
    r = rem_r;
    for (int k = 0; k < mwma_pkg::DIV_STEPS; k++) begin
      t = {r, n[NW-1]};
      n = {n[NW-2:0], 1'b0};
      if (t >= {1'b0, len_r}) begin
        t    = t - {1'b0, len_r};
        n[0] = 1'b1;
      end
      r = t[LW-1:0];
    end
    num_nxt = n;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            num_r   <= {mag, {mwma_pkg::FRAC_BITS{1'b0}}};
            rem_r   <= '0;
            neg_r   <= q_head.sum[mwma_pkg::SUM_W-1];
            slot_r  <= q_head.slot;
            len_r   <= q_head.len;
            last_r  <= q_head.last;
            step_r  <= '0;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          num_r  <= num_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == mwma_pkg::STEP_W'(mwma_pkg::DIV_ITERS - 1)) begin
            state_r <= B_DONE;
          end
        end
        B_DONE: begin
          if (load_out) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_slot_r <= slot_r;
      o_len_r  <= len_r;
      o_avg_r  <= quot[mwma_pkg::AVG_W-1:0];
      o_last_r <= last_r;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_window_slot   = o_slot_r;
  assign out_window_length = o_len_r;
  assign out_average       = o_avg_r;
  assign out_last          = o_last_r;

  property p_no_pop_busy;
    @(posedge clk) disable iff (!rst_n)
      q_pop |=> (state_r == B_DIV) && (step_r == '0);
  endproperty
  a_no_pop_busy: assert property (p_no_pop_busy) else $error("divider load lost");

  property p_div_len;
    @(posedge clk) disable iff (!rst_n)
      (state_r == B_DIV) |-> (len_r != '0) && (rem_r < len_r);
  endproperty
  a_div_len: assert property (p_div_len) else $error("divider remainder out of range");

  property p_last_slot;
    @(posedge clk) disable iff (!rst_n)
      (out_valid_r && o_last_r) |-> (o_slot_r == '0);
  endproperty
  a_last_slot: assert property (p_last_slot) else $error("last on nonzero slot");

endmodule

// ----- hw/rtl/multi_window_moving_average_core.sv -----
// ----------------------------------------------------------------------------
// multi_window_moving_average_core
// Ring-based moving averages over up to four windows, 8 fraction bits.
// ----------------------------------------------------------------------------
// Front end: a ring read and a sum update for every window, a ring write, then,
// once the fill reaches the longest window, one emit per active window, each
// held while the job queue is full. Back end: a load, eight 4-bit divide steps
// and a hand-off per average, one average at a time, the hand-off held while an
// unpopped result is waiting. Reset is synchronous; a configuration write
// restarts averaging, stale ring entries are masked by the fill count.
module multi_window_moving_average_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [mwma_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mwma_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_push,
  input  logic signed [mwma_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                    full,
  output logic                                    empty,
  input  logic                                    pop,
  output logic [mwma_pkg::SLOT_W-1:0]             out_window_slot,
  output logic [mwma_pkg::LEN_W-1:0]              out_window_length,
  output logic signed [mwma_pkg::AVG_W-1:0]       out_average,
  output logic                                    out_last
);

  logic [mwma_pkg::CNT_W-1:0]   count_r;
  logic [mwma_pkg::LEN_W-1:0]   len_reg_r [mwma_pkg::LENGTH_REGS];
  logic [mwma_pkg::LEN_W-1:0]   longest;
  mwma_pkg::ctrl_t              ctrl;
  logic                         q_push;
  mwma_pkg::job_t               q_job;
  logic                         q_full;
  logic                         q_pop;
  mwma_pkg::job_t               q_head;
  logic                         q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= mwma_pkg::CNT_W'(4);
      len_reg_r[0] <= mwma_pkg::LEN_W'(256);
      len_reg_r[1] <= mwma_pkg::LEN_W'(64);
      len_reg_r[2] <= mwma_pkg::LEN_W'(16);
      len_reg_r[3] <= mwma_pkg::LEN_W'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        mwma_pkg::CFG_WINDOW_COUNT:   count_r      <= cfg_data[mwma_pkg::CNT_W-1:0];
        mwma_pkg::CFG_LONGEST_WINDOW: len_reg_r[0] <= cfg_data;
        mwma_pkg::CFG_SECOND_WINDOW:  len_reg_r[1] <= cfg_data;
        mwma_pkg::CFG_THIRD_WINDOW:   len_reg_r[2] <= cfg_data;
        mwma_pkg::CFG_FOURTH_WINDOW:  len_reg_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign longest = mwma_pkg::clamp_len(len_reg_r[0],
                                       mwma_pkg::LEN_W'(mwma_pkg::RING_DEPTH));

  always_comb begin
    ctrl.clear = cfg_we && (cfg_index <= mwma_pkg::CFG_FOURTH_WINDOW);
    if (count_r == '0) begin
      ctrl.active = mwma_pkg::CNT_W'(1);
    end else if (count_r > mwma_pkg::CNT_W'(mwma_pkg::NUM_SLOTS)) begin
      ctrl.active = mwma_pkg::CNT_W'(mwma_pkg::NUM_SLOTS);
    end else begin
      ctrl.active = count_r;
    end
    for (int i = 0; i < mwma_pkg::NUM_SLOTS; i++) begin
      ctrl.len[i] = mwma_pkg::clamp_len(len_reg_r[i], longest);
    end
  end

  mwma_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_full   (full),
    .q_push    (q_push),
    .q_job     (q_job),
    .q_full    (q_full)
  );

  mwma_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  mwma_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_empty         (empty),
    .out_pop           (pop),
    .out_window_slot   (out_window_slot),
    .out_window_length (out_window_length),
    .out_average       (out_average),
    .out_last          (out_last)
  );

endmodule

// ----- tb/tb_multi_window_moving_average_core.sv -----
// ----------------------------------------------------------------------------
// tb_multi_window_moving_average_core
// Feeds signed samples through several window settings, predicts every
// average in a scoreboard of its own and checks each popped result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_window_moving_average_core;
  import mwma_pkg::*;

  localparam int  SETTLE_CYCLES = 200;
  localparam int  LONG_HOLD     = 1500;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [SLOT_W-1:0]       slot;
    logic [LEN_W-1:0]        len;
    logic signed [AVG_W-1:0] avg;
    logic                    last;
  } avg_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_push = 1'b0;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  logic [SLOT_W-1:0] out_window_slot;
  logic [LEN_W-1:0] out_window_length;
  logic signed [AVG_W-1:0] out_average;
  logic out_last;

  logic signed [SAMPLE_BITS-1:0] sample_queue[$];
  avg_result_t expected_avgs[$];
  int     error_count = 0;
  longint cycle_count = 0;
  bit     gaps_on;
  logic   hold_start;
  int     hold_left;
  int     send_gap = 0;
  int     recv_gap = 0;

  // scoreboard copy of the averaging state
  logic [2:0]       win_count_reg;
  logic [LEN_W-1:0] win_len_reg[4];
  int               sample_hist[RING_DEPTH];
  int               win_sums[4];
  int               newest;
  int               filled;

  multi_window_moving_average_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_sample(in_sample), .full(full), .empty(empty), .pop(pop),
    .out_window_slot(out_window_slot), .out_window_length(out_window_length),
    .out_average(out_average), .out_last(out_last)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int longest_len();
    int v;
    v = win_len_reg[0];
    if (v < 1) v = 1;
    if (v > RING_DEPTH) v = RING_DEPTH;
    return v;
  endfunction

  function automatic int window_len(int slot);
    int v;
    int top;
    top = longest_len();
    v = win_len_reg[slot];
    if (v < 1) v = 1;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic void clear_averages();
    foreach (sample_hist[i]) sample_hist[i] = 0;
    foreach (win_sums[i]) win_sums[i] = 0;
    newest = 0;
    filled = 0;
  endfunction

  function automatic void predict_averages(logic signed [SAMPLE_BITS-1:0] s);
    int n;
    int len;
    int old;
    longint num;
    longint q;
    avg_result_t r;
    newest = (newest + 1) % RING_DEPTH;
    for (int slot = 0; slot < 4; slot++) begin
      len = window_len(slot);
      old = (newest + RING_DEPTH - len) % RING_DEPTH;
      win_sums[slot] += int'(s) - sample_hist[old];
    end
    sample_hist[newest] = s;
    if (filled < RING_DEPTH) filled++;
    if (filled < longest_len()) return;
    n = win_count_reg;
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    for (int slot = n - 1; slot >= 0; slot--) begin
      len = window_len(slot);
      num = longint'(win_sums[slot]) * 256;
      q = num / len;
      if ((num % len) != 0 && num < 0) q = q - 1;
      r.slot = SLOT_W'(slot);
      r.len  = LEN_W'(len);
      r.avg  = q[AVG_W-1:0];
      r.last = (slot == 0);
      expected_avgs.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW_COUNT) win_count_reg = value[2:0];
    else win_len_reg[idx - 1] = value[LEN_W-1:0];
    clear_averages();
  endtask

  task automatic set_windows(int cnt, int l0, int l1, int l2, int l3);
    write_reg(CFG_WINDOW_COUNT, cnt);
    write_reg(CFG_LONGEST_WINDOW, l0);
    write_reg(CFG_SECOND_WINDOW, l1);
    write_reg(CFG_THIRD_WINDOW, l2);
    write_reg(CFG_FOURTH_WINDOW, l3);
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_push || expected_avgs.size() != 0 || hold_left != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    logic signed [SAMPLE_BITS-1:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: s = 16'sh7fff;
        1: s = 16'sh8000;
        default: s = SAMPLE_BITS'($urandom);
      endcase
      sample_queue.push_back(s);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout");
      $display("tb_multi_window_moving_average_core failed");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    int gap;
    gap = send_gap;
    if (!rst_n) begin
      in_push  <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_push && !full) predict_averages(in_sample);
      if (!(in_push && full)) begin
        if (gap > 0) begin
          in_push  <= 1'b0;
          send_gap <= gap - 1;
        end else if (sample_queue.size() != 0) begin
          in_push   <= 1'b1;
          in_sample <= sample_queue.pop_front();
          send_gap  <= gaps_on ? $urandom_range(0, 17) : 0;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_start) hold_left <= LONG_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver
  always @(posedge clk) begin
    int gap;
    avg_result_t e;
    gap = recv_gap;
    if (!rst_n) begin
      pop      <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_avgs.size() == 0) begin
          report_mismatch("unexpected transaction, slot", out_window_slot, -1);
        end else begin
          e = expected_avgs.pop_front();
          if (out_window_slot !== e.slot) report_mismatch("window_slot", out_window_slot, e.slot);
          if (out_window_length !== e.len)
            report_mismatch("window_length", out_window_length, e.len);
          if (out_average !== e.avg) report_mismatch("average", out_average, e.avg);
          if (out_last !== e.last) report_mismatch("last", out_last, e.last);
        end
        gap = gaps_on ? $urandom_range(0, 17) : 0;
      end
      if (hold_start || hold_left > 1) begin
        pop      <= 1'b0;
        recv_gap <= gap;
      end else if (gap > 0) begin
        pop      <= 1'b0;
        recv_gap <= gap - 1;
      end else begin
        pop      <= 1'b1;
        recv_gap <= 0;
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    hold_start  = 1'b0;
    gaps_on     = 1'b0;
    win_count_reg = 3'd4;
    win_len_reg[0] = 9'd256;
    win_len_reg[1] = 9'd64;
    win_len_reg[2] = 9'd16;
    win_len_reg[3] = 9'd4;
    clear_averages();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full-scale steps through nested windows down to length one
    set_windows(4, 6, 4, 2, 1);
    repeat (6) sample_queue.push_back(16'sh7fff);
    repeat (6) sample_queue.push_back(16'sh8000);
    sample_queue.push_back(16'sh0000);
    sample_queue.push_back(-16'sd1);
    sample_queue.push_back(16'sd1);
    sample_queue.push_back(-16'sd3);
    sample_queue.push_back(16'sh5555);
    sample_queue.push_back(16'shaaaa);
    wait_idle();

    // zero count and zero lengths fall back to one
    gaps_on = 1'b1;
    set_windows(0, 0, 0, 0, 0);
    queue_random(40);
    wait_idle();

    // over-range count clamps to four windows, over-range lengths to the ring
    set_windows(7, 300, 511, 100, 3);
    queue_random(270);
    wait_idle();

    // repeated and over-long lengths, receiver backs up
    set_windows(2, 12, 12, 20, 5);
    queue_random(30);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    queue_random(50);
    wait_idle();

    gaps_on = 1'b0;
    set_windows(3, 3, 7, 1, 2);
    queue_random(40);
    wait_idle();

    gaps_on = 1'b1;
    set_windows(5, 32, 16, 8, 2);
    queue_random(40);
    wait_idle();

    if (error_count == 0) $display("tb_multi_window_moving_average_core passed");
    else $display("tb_multi_window_moving_average_core failed");
    $finish;
  end

endmodule
